// ===== hw/rtl/tpbr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpbr_pkg
// Shared types, constants and the binomial coefficient table for the
// two-piece board ranker.
// ----------------------------------------------------------------------------
package tpbr_pkg;

    localparam int MaxCells     = 32;
    localparam int CELL_W       = 6;   // holds 0..32
    localparam int BINOM_W      = 30;  // C(32,16) < 2**30
    localparam int HASH_W       = 48;
    localparam int QUOT_W       = HASH_W - 1;
    localparam int BINOM_ROWS   = MaxCells + 1;
    localparam int BINOM_ENTRIES = BINOM_ROWS * BINOM_ROWS;
    localparam int BIDX_W       = $clog2(BINOM_ENTRIES);

    localparam logic [CELL_W-1:0] DIV_STEPS = CELL_W'(QUOT_W);
    localparam logic [CELL_W-1:0] CELLS_MAX = CELL_W'(MaxCells);

    typedef logic [BINOM_W-1:0] binom_tbl_t [BINOM_ENTRIES];

    // Build Pascal's triangle, row p at offset p*BINOM_ROWS
    function automatic binom_tbl_t build_binom();
        binom_tbl_t t;
        for (int p = 0; p < BINOM_ROWS; p++)
        begin
            for (int k = 0; k < BINOM_ROWS; k++)
            begin
                if (k == 0)
                    t[p*BINOM_ROWS] = BINOM_W'(1);
                else if (p == 0)
                    t[k] = '0;
                else
                    t[p*BINOM_ROWS+k] = t[(p-1)*BINOM_ROWS+k-1] + t[(p-1)*BINOM_ROWS+k];
            end
        end
        return t;
    endfunction

    localparam binom_tbl_t BINOM_TBL = build_binom();

    // Flat table index of C(p,k)
    function automatic logic [BIDX_W-1:0] binom_index(logic [CELL_W-1:0] p,
                                                      logic [CELL_W-1:0] k);
        logic [BIDX_W-1:0] pw;
        pw = BIDX_W'(p);
        return BIDX_W'(pw * BIDX_W'(BINOM_ROWS)) + BIDX_W'(k);
    endfunction

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_COMP,
        OP_RX_SETUP,
        OP_RANK_RD,
        OP_RANK_ACC,
        OP_RO_SETUP,
        OP_OFF_RD,
        OP_OFF_LD,
        OP_MUL,
        OP_SUM,
        OP_ERR,
        OP_DIV_STEP,
        OP_TIER_RD,
        OP_UX_SETUP,
        OP_UN_RD,
        OP_UN_CMP,
        OP_UO_SETUP,
        OP_DEP_SETUP,
        OP_DEP_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic unhash;
        logic tier_bad;
        logic scan_done;
        logic un_done;
        logic idx_bad;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/tpbr_dp.sv =====
// ----------------------------------------------------------------------------
// tpbr_dp
// Datapath: operand registers, bit scanner, binomial table read port,
// restoring divider, multiplier and the output register.
// ----------------------------------------------------------------------------
module tpbr_dp
    import tpbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [CELL_W-1:0]   cell_count,
    input  logic                in_command,
    input  logic [31:0]         in_x_bits,
    input  logic [31:0]         in_o_bits,
    input  logic                in_turn,
    input  logic [HASH_W-1:0]   in_hash_value,
    input  logic [CELL_W-1:0]   in_x_count,
    input  logic [CELL_W-1:0]   in_o_count,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [HASH_W-1:0]   hash_out,
    output logic [31:0]         x_bits_out,
    output logic [31:0]         o_bits_out,
    output logic                turn_out,
    output logic                error
);

    logic                 unhash_reg;
    logic                 turn_reg;
    logic [31:0]          x_reg;
    logic [31:0]          o_reg;
    logic [QUOT_W-1:0]    h_reg;
    logic [CELL_W-1:0]    xc_reg;
    logic [CELL_W-1:0]    oc_reg;
    logic [CELL_W-1:0]    n_reg;
    logic [31:0]          so_reg;
    logic [31:0]          sx_reg;
    logic [31:0]          oo_reg;
    logic [31:0]          mask_reg;
    logic [CELL_W-1:0]    px_reg;
    logic [CELL_W-1:0]    po_reg;
    logic [CELL_W-1:0]    pos_reg;
    logic [CELL_W-1:0]    len_reg;
    logic [CELL_W-1:0]    j_reg;
    logic [CELL_W-1:0]    k_reg;
    logic [BINOM_W-1:0]   acc_reg;
    logic [BINOM_W-1:0]   rem_reg;
    logic [BINOM_W-1:0]   off_reg;
    logic [BINOM_W-1:0]   rankx_reg;
    logic [BINOM_W-1:0]   rom_q_reg;
    logic [QUOT_W-1:0]    prod_reg;
    logic [QUOT_W-1:0]    sum_reg;
    logic                 err_reg;

    logic [CELL_W-1:0]    n_eff;
    logic [31:0]          full_mask;
    logic [BIDX_W-1:0]    rom_addr;
    logic [BINOM_W:0]     div_shift;
    logic [BINOM_W:0]     div_diff;
    logic                 div_ge;
    logic [2*BINOM_W-1:0] mult;
    logic [4:0]           pos_i;
    logic [4:0]           j_i;

    // Clamp board size into 1..MaxCells
    always_comb
    begin
        if (cell_count == '0)
            n_eff = CELL_W'(1);
        else if (cell_count > CELLS_MAX)
            n_eff = CELLS_MAX;
        else
            n_eff = cell_count;
    end

    assign full_mask = ~({32{1'b1}} << n_eff);
    assign pos_i     = pos_reg[4:0];
    assign j_i       = j_reg[4:0];

    // Select the binomial to fetch
    always_comb
    begin
        case (cmd.op)
            OP_RANK_RD: rom_addr = binom_index(pos_reg, k_reg + CELL_W'(1));
            OP_UN_RD:   rom_addr = binom_index(pos_reg - CELL_W'(1), k_reg);
            OP_OFF_RD:
            begin
                if (unhash_reg)
                    rom_addr = binom_index(n_reg - xc_reg, oc_reg);
                else
                    rom_addr = binom_index(n_reg - px_reg, po_reg);
            end
            OP_TIER_RD: rom_addr = binom_index(n_reg, xc_reg);
            default:    rom_addr = '0;
        endcase
    end

    // One restoring divide step
    assign div_shift = {rem_reg, h_reg[QUOT_W-1]};
    assign div_ge    = div_shift >= {1'b0, off_reg};
    assign div_diff  = div_shift - {1'b0, off_reg};
    assign mult      = (2*BINOM_W)'(off_reg) * (2*BINOM_W)'(rankx_reg);

    // Table read port
    always_ff @(posedge clk)
    begin
        rom_q_reg <= BINOM_TBL[rom_addr];
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                unhash_reg <= in_command;
                x_reg      <= in_x_bits & full_mask;
                o_reg      <= in_o_bits & full_mask;
                turn_reg   <= in_command ? in_hash_value[0] : in_turn;
                h_reg      <= in_hash_value[HASH_W-1:1];
                xc_reg     <= in_x_count;
                oc_reg     <= in_o_count;
                n_reg      <= n_eff;
                so_reg     <= '0;
                px_reg     <= '0;
                po_reg     <= '0;
                pos_reg    <= '0;
                j_reg      <= '0;
                len_reg    <= n_eff;
                err_reg    <= 1'b0;
            end
            OP_COMP:
            begin
                if (!x_reg[pos_i])
                begin
                    if (o_reg[pos_i])
                    begin
                        so_reg[j_i] <= 1'b1;
                        po_reg      <= po_reg + CELL_W'(1);
                    end
                    j_reg <= j_reg + CELL_W'(1);
                end
                else
                begin
                    px_reg <= px_reg + CELL_W'(1);
                end
                pos_reg <= pos_reg + CELL_W'(1);
            end
            OP_RX_SETUP:
            begin
                mask_reg <= x_reg;
                pos_reg  <= '0;
                k_reg    <= '0;
                acc_reg  <= '0;
                len_reg  <= n_reg;
            end
            OP_RANK_ACC:
            begin
                if (mask_reg[pos_i])
                begin
                    acc_reg <= acc_reg + rom_q_reg;
                    k_reg   <= k_reg + CELL_W'(1);
                end
                pos_reg <= pos_reg + CELL_W'(1);
            end
            OP_RO_SETUP:
            begin
                rankx_reg <= acc_reg;
                mask_reg  <= so_reg;
                pos_reg   <= '0;
                k_reg     <= '0;
                acc_reg   <= '0;
                len_reg   <= n_reg - px_reg;
            end
            OP_OFF_LD:
            begin
                off_reg <= rom_q_reg;
                rem_reg <= '0;
                pos_reg <= '0;
                len_reg <= DIV_STEPS;
            end
            OP_MUL:
            begin
                prod_reg <= mult[QUOT_W-1:0];
            end
            OP_SUM:
            begin
                sum_reg <= prod_reg + QUOT_W'(acc_reg);
            end
            OP_ERR:
            begin
                err_reg <= 1'b1;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? div_diff[BINOM_W-1:0] : div_shift[BINOM_W-1:0];
                h_reg   <= {h_reg[QUOT_W-2:0], div_ge};
                pos_reg <= pos_reg + CELL_W'(1);
            end
            OP_UX_SETUP:
            begin
                acc_reg  <= h_reg[BINOM_W-1:0];
                k_reg    <= xc_reg;
                pos_reg  <= n_reg;
                mask_reg <= '0;
            end
            OP_UN_RD:
            begin
                pos_reg <= pos_reg - CELL_W'(1);
            end
            OP_UN_CMP:
            begin
                if (rom_q_reg <= acc_reg)
                begin
                    mask_reg[pos_i] <= 1'b1;
                    acc_reg         <= acc_reg - rom_q_reg;
                    k_reg           <= k_reg - CELL_W'(1);
                end
            end
            OP_UO_SETUP:
            begin
                sx_reg   <= mask_reg;
                acc_reg  <= rem_reg;
                k_reg    <= oc_reg;
                pos_reg  <= n_reg - xc_reg;
                mask_reg <= '0;
            end
            OP_DEP_SETUP:
            begin
                so_reg  <= mask_reg;
                pos_reg <= '0;
                j_reg   <= '0;
                len_reg <= n_reg;
                oo_reg  <= '0;
            end
            OP_DEP_STEP:
            begin
                if (!sx_reg[pos_i])
                begin
                    if (so_reg[j_i])
                        oo_reg[pos_i] <= 1'b1;
                    j_reg <= j_reg + CELL_W'(1);
                end
                pos_reg <= pos_reg + CELL_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            hash_out   <= unhash_reg ? '0 : {sum_reg, turn_reg};
            x_bits_out <= (unhash_reg && !err_reg) ? sx_reg : '0;
            o_bits_out <= (unhash_reg && !err_reg) ? oo_reg : '0;
            turn_out   <= turn_reg;
            error      <= err_reg;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    assign status.unhash    = unhash_reg;
    assign status.tier_bad  = (xc_reg > n_reg) || (oc_reg > (n_reg - xc_reg));
    assign status.scan_done = pos_reg == len_reg;
    assign status.un_done   = (pos_reg == '0) || (k_reg == '0);
    assign status.idx_bad   = h_reg >= QUOT_W'(rom_q_reg);
    assign status.out_free  = !out_valid || out_ready;

endmodule

// ===== hw/rtl/tpbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpbr_ctrl
// Sequencer: walks one item through compress, rank, multiply, or through
// divide, range check, unrank and deposit, then loads the output register.
// ----------------------------------------------------------------------------
module tpbr_ctrl
    import tpbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dp_status_t  status,
    output dp_cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_BRANCH,
        S_COMP,
        S_RX_RD,
        S_RX_ACC,
        S_RO_RD,
        S_RO_ACC,
        S_OFF_LD,
        S_MUL,
        S_SUM,
        S_ERR,
        S_DIV,
        S_TIER_CHK,
        S_UX_RD,
        S_UX_CMP,
        S_UO_RD,
        S_UO_CMP,
        S_DEP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode command and next state
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NOP;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_BRANCH;
                end
            end
            S_BRANCH:
            begin
                if (!status.unhash)
                    state_next = S_COMP;
                else if (status.tier_bad)
                    state_next = S_ERR;
                else
                begin
                    cmd.op     = OP_OFF_RD;
                    state_next = S_OFF_LD;
                end
            end
            S_COMP:
            begin
                if (status.scan_done)
                begin
                    cmd.op     = OP_RX_SETUP;
                    state_next = S_RX_RD;
                end
                else
                    cmd.op = OP_COMP;
            end
            S_RX_RD:
            begin
                if (status.scan_done)
                begin
                    cmd.op     = OP_RO_SETUP;
                    state_next = S_RO_RD;
                end
                else
                begin
                    cmd.op     = OP_RANK_RD;
                    state_next = S_RX_ACC;
                end
            end
            S_RX_ACC:
            begin
                cmd.op     = OP_RANK_ACC;
                state_next = S_RX_RD;
            end
            S_RO_RD:
            begin
                if (status.scan_done)
                begin
                    cmd.op     = OP_OFF_RD;
                    state_next = S_OFF_LD;
                end
                else
                begin
                    cmd.op     = OP_RANK_RD;
                    state_next = S_RO_ACC;
                end
            end
            S_RO_ACC:
            begin
                cmd.op     = OP_RANK_ACC;
                state_next = S_RO_RD;
            end
            S_OFF_LD:
            begin
                cmd.op     = OP_OFF_LD;
                state_next = status.unhash ? S_DIV : S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = S_DONE;
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (status.scan_done)
                begin
                    cmd.op     = OP_TIER_RD;
                    state_next = S_TIER_CHK;
                end
                else
                    cmd.op = OP_DIV_STEP;
            end
            S_TIER_CHK:
            begin
                if (status.idx_bad)
                begin
                    cmd.op     = OP_ERR;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_UX_SETUP;
                    state_next = S_UX_RD;
                end
            end
            S_UX_RD:
            begin
                if (status.un_done)
                begin
                    cmd.op     = OP_UO_SETUP;
                    state_next = S_UO_RD;
                end
                else
                begin
                    cmd.op     = OP_UN_RD;
                    state_next = S_UX_CMP;
                end
            end
            S_UX_CMP:
            begin
                cmd.op     = OP_UN_CMP;
                state_next = S_UX_RD;
            end
            S_UO_RD:
            begin
                if (status.un_done)
                begin
                    cmd.op     = OP_DEP_SETUP;
                    state_next = S_DEP;
                end
                else
                begin
                    cmd.op     = OP_UN_RD;
                    state_next = S_UO_CMP;
                end
            end
            S_UO_CMP:
            begin
                cmd.op     = OP_UN_CMP;
                state_next = S_UO_RD;
            end
            S_DEP:
            begin
                if (status.scan_done)
                    state_next = S_DONE;
                else
                    cmd.op = OP_DEP_STEP;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/two_piece_board_rank_unrank.sv =====
// ----------------------------------------------------------------------------
// two_piece_board_rank_unrank
// Hashes an X/O board plus turn bit to a dense index and unhashes it back.
// ----------------------------------------------------------------------------
// One item at a time. A hash compresses the O mask cell by cell, then runs
// two ranking passes, one over all n cells for X and one over the cells
// not held by X for the compressed O mask; each ranking step waits on the
// registered binomial table read. An unhash runs the bit-serial divider,
// then one unranking pass for X and one for O (a pass ends early once all
// its pieces are placed) and deposits the O bits cell by cell. A bad tier
// goes straight to the error result. A new item is taken once the result
// is in the output register, even if it is not yet taken downstream.
module two_piece_board_rank_unrank
    import tpbr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // Configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // Input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // x_bits[31:0], o_bits[63:32], turn[64], hash_value[112:65],
    // x_count[118:113], o_count[124:119], zero fill[127:125]
    input  logic [127:0]  s_axis_tdata,
    // command[0]
    input  logic [0:0]    s_axis_tuser,
    // Output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // hash_out[47:0], x_bits_out[79:48], o_bits_out[111:80], turn_out[112],
    // zero fill[119:113]
    output logic [119:0]  m_axis_tdata,
    // error[0]
    output logic [0:0]    m_axis_tuser
);

    logic [CELL_W-1:0] cell_count_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [HASH_W-1:0] hash_out;
    logic [31:0]       x_bits_out;
    logic [31:0]       o_bits_out;
    logic              turn_out;
    logic              error;

    // Register file write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_count_reg <= CELLS_MAX;
        else if (psel && penable && pwrite && !paddr[2])
            cell_count_reg <= pwdata[CELL_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : {{(32-CELL_W){1'b0}}, cell_count_reg};

    tpbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tpbr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cell_count    (cell_count_reg),
        .in_command    (s_axis_tuser[0]),
        .in_x_bits     (s_axis_tdata[31:0]),
        .in_o_bits     (s_axis_tdata[63:32]),
        .in_turn       (s_axis_tdata[64]),
        .in_hash_value (s_axis_tdata[112:65]),
        .in_x_count    (s_axis_tdata[118:113]),
        .in_o_count    (s_axis_tdata[124:119]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .hash_out      (hash_out),
        .x_bits_out    (x_bits_out),
        .o_bits_out    (o_bits_out),
        .turn_out      (turn_out),
        .error         (error)
    );

    assign m_axis_tdata = {7'b0, turn_out, o_bits_out, x_bits_out, hash_out};
    assign m_axis_tuser = error;

    // Busy after every accepted transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // An error result carries no board
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[111:48] == '0))
        else $error("error result with nonzero board");

    // Errors only come from unhash, which reports no hash
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[47:0] == '0))
        else $error("error result with nonzero hash");

endmodule
